/* design/dq_pkg.sv */
// dq_pkg: shared types and constants for the double-ended queue core
// used by dq_ctrl, dq_datapath and double_ended_queue_core; no dependencies
`timescale 1ns / 1ps

package dq_pkg;

   // ring store depth and derived widths
   localparam int DEPTH   = 1024;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;
   localparam int MODE_W  = 3;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 11;

   // operation codes carried by a request
   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_PEEK_FRONT = 3'd4,
      MODE_PEEK_BACK  = 3'd5,
      MODE_CLEAR      = 3'd6,
      MODE_SIZE       = 3'd7
   } mode_type;

   // response status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic take;     // request transaction accepted this cycle
      logic finish;   // store read data is ready, load the response
   } dq_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic read_op;  // accepted request needs a store read
      logic out_busy; // response register holds a result that stays this cycle
   } dq_stat_type;

endpackage

/* design/double_ended_queue_core.sv */
// double_ended_queue_core: top level of the double-ended queue of signed words
// depends on dq_pkg, dq_ctrl and dq_datapath
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_mode, req_push_value
//   rsp     | out       | rsp_valid/rsp_stall | rsp_status, rsp_data_out, rsp_entry_count
//
// pushes, clear, size and errors load the response register on acceptance; pops and peeks
// first go through the registered read port of the ring store and the ST_READ state
// reset clears pointers, count, state and response valid; store is not cleared
// a waiting response holds the next request off only while rsp_stall is high
`timescale 1ns / 1ps

module double_ended_queue_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [dq_pkg::MODE_W-1:0]   req_mode,
   input  logic signed [dq_pkg::DATA_W-1:0] req_push_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [dq_pkg::STAT_W-1:0]   rsp_status,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_data_out,
   output logic [dq_pkg::COUNT_W-1:0]  rsp_entry_count
);

   dq_pkg::dq_cmd_type  cmd;
   dq_pkg::dq_stat_type stat;

   // controller
   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   dq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_push_value  (req_push_value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

/* design/dq_ctrl.sv */
// dq_ctrl: controller state machine of the double-ended queue core
// depends on dq_pkg for the state, command and status types
`timescale 1ns / 1ps

module dq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dq_pkg::dq_stat_type stat,
   output dq_pkg::dq_cmd_type  cmd
);

   dq_pkg::state_type state_ff;
   dq_pkg::state_type state_in;
   logic              take;

   // accept only when idle and the response register frees up
   assign req_stall = (state_ff != dq_pkg::ST_IDLE) || stat.out_busy;
   assign take      = req_valid && !req_stall;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dq_pkg::ST_IDLE: begin
            if (take && stat.read_op) begin
               state_in = dq_pkg::ST_READ;
            end
         end
         dq_pkg::ST_READ: begin
            state_in = dq_pkg::ST_IDLE;
         end
         default: begin
            state_in = dq_pkg::ST_IDLE;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd.take   = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         dq_pkg::ST_IDLE: begin
            cmd.take = take;
         end
         dq_pkg::ST_READ: begin
            cmd.finish = 1'b1;
         end
         default: begin
            cmd.take   = 1'b0;
            cmd.finish = 1'b0;
         end
      endcase
   end

endmodule

/* design/dq_datapath.sv */
// dq_datapath: ring store, front and back pointers, count and response register
// depends on dq_pkg for widths, operation codes and the command/status types
`timescale 1ns / 1ps

module dq_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [dq_pkg::MODE_W-1:0]   req_mode,
   input  logic signed [dq_pkg::DATA_W-1:0] req_push_value,
   input  dq_pkg::dq_cmd_type          cmd,
   output dq_pkg::dq_stat_type         stat,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [dq_pkg::STAT_W-1:0]   rsp_status,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_data_out,
   output logic [dq_pkg::COUNT_W-1:0]  rsp_entry_count
);

   localparam int AW = dq_pkg::ADDR_W;
   localparam int CW = dq_pkg::CNT_W;
   localparam int DW = dq_pkg::DATA_W;

   logic [DW-1:0]    mem [dq_pkg::DEPTH];
   logic [DW-1:0]    rd_data_ff;

   logic [AW-1:0]    front_ff, front_in;
   logic [AW-1:0]    back_ff, back_in;
   logic [CW-1:0]    count_ff, count_in;

   logic             rsp_valid_ff;
   dq_pkg::status_type rsp_status_ff;
   logic [DW-1:0]    rsp_data_ff;
   logic [dq_pkg::COUNT_W-1:0] rsp_count_ff;

   dq_pkg::mode_type mode;
   dq_pkg::status_type status_now;
   logic             is_empty, is_full, read_op;
   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [AW-1:0]    front_inc, front_dec, back_inc, back_dec;
   logic [dq_pkg::COUNT_W+CW-1:0] count_in_ext, count_ff_ext;

   // wrapping pointer neighbors
   assign front_inc = (front_ff == AW'(dq_pkg::DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign front_dec = (front_ff == '0) ? AW'(dq_pkg::DEPTH - 1) : front_ff - 1'b1;
   assign back_inc  = (back_ff == AW'(dq_pkg::DEPTH - 1)) ? '0 : back_ff + 1'b1;
   assign back_dec  = (back_ff == '0) ? AW'(dq_pkg::DEPTH - 1) : back_ff - 1'b1;

   assign mode     = dq_pkg::mode_type'(req_mode);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CW'(dq_pkg::DEPTH));

   // operation decode: next pointers, store access and immediate status
   always_comb begin
      front_in   = front_ff;
      back_in    = back_ff;
      count_in   = count_ff;
      wr_en      = 1'b0;
      wr_addr    = back_ff;
      rd_addr    = front_ff;
      read_op    = 1'b0;
      status_now = dq_pkg::STAT_OK;
      unique case (mode)
         dq_pkg::MODE_PUSH_FRONT: begin
            if (is_full) begin
               status_now = dq_pkg::STAT_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = front_dec;
               front_in = front_dec;
               count_in = count_ff + 1'b1;
            end
         end
         dq_pkg::MODE_PUSH_BACK: begin
            if (is_full) begin
               status_now = dq_pkg::STAT_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = back_ff;
               back_in  = back_inc;
               count_in = count_ff + 1'b1;
            end
         end
         dq_pkg::MODE_POP_FRONT: begin
            if (is_empty) begin
               status_now = dq_pkg::STAT_EMPTY;
            end else begin
               read_op  = 1'b1;
               rd_addr  = front_ff;
               front_in = front_inc;
               count_in = count_ff - 1'b1;
            end
         end
         dq_pkg::MODE_POP_BACK: begin
            if (is_empty) begin
               status_now = dq_pkg::STAT_EMPTY;
            end else begin
               read_op  = 1'b1;
               rd_addr  = back_dec;
               back_in  = back_dec;
               count_in = count_ff - 1'b1;
            end
         end
         dq_pkg::MODE_PEEK_FRONT: begin
            if (is_empty) begin
               status_now = dq_pkg::STAT_EMPTY;
            end else begin
               read_op = 1'b1;
               rd_addr = front_ff;
            end
         end
         dq_pkg::MODE_PEEK_BACK: begin
            if (is_empty) begin
               status_now = dq_pkg::STAT_EMPTY;
            end else begin
               read_op = 1'b1;
               rd_addr = back_dec;
            end
         end
         dq_pkg::MODE_CLEAR: begin
            front_in = '0;
            back_in  = '0;
            count_in = '0;
         end
         dq_pkg::MODE_SIZE: begin
            status_now = dq_pkg::STAT_OK;
         end
         default: begin
            status_now = dq_pkg::STAT_OK;
         end
      endcase
   end

   assign stat.read_op  = read_op;
   assign stat.out_busy = rsp_valid_ff && rsp_stall;

   // count masked to the response field width
   assign count_in_ext = {{dq_pkg::COUNT_W{1'b0}}, count_in};
   assign count_ff_ext = {{dq_pkg::COUNT_W{1'b0}}, count_ff};

   // ring store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.take && wr_en) begin
         mem[wr_addr] <= req_push_value;
      end
      if (cmd.take) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.take) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   // response valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((cmd.take && !read_op) || cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= dq_pkg::STAT_OK;
         rsp_data_ff   <= rd_data_ff;
         rsp_count_ff  <= count_ff_ext[dq_pkg::COUNT_W-1:0];
      end else if (cmd.take && !read_op) begin
         rsp_status_ff <= status_now;
         rsp_data_ff   <= '0;
         rsp_count_ff  <= count_in_ext[dq_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
